[rtl/hrp_pkg.sv]
// shared types and constants for the http request head parser
`timescale 1ns / 1ps
`default_nettype none
package hrp_pkg;

	localparam int MAX_REQUEST_BYTES = 8192;
	localparam int SPAN_W = 13;
	localparam int OFS_W = $clog2(MAX_REQUEST_BYTES + 1);
	localparam int MAX_RES = 4;
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int FIFO_DEPTH = 8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} octet_t;

	typedef struct packed {
		logic [3:0]        event_res;
		logic [SPAN_W-1:0] span_start;
		logic [SPAN_W-1:0] span_end;
		logic              last_of_run;
	} span_word_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]           cnt;
		span_word_t [MAX_RES-1:0]       item;
	} res_bundle_t;

endpackage
`default_nettype wire

[rtl/http_request_head_parser.sv]
// http request head parser top level
// a taken byte word is held in word_s1 and is parsed once the result queue has
//   four free slots; its results are then written into the queue
// throughput: one byte word per cycle; results leave at one per cycle from an
//   eight-entry queue, so only bursts of multi-result bytes or a stalled output cause stall
// reset: parser back to request line start, offset zero, queue empty
`timescale 1ns / 1ps
`default_nettype none
module http_request_head_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 octet_valid,
	output logic                octet_stall,
	input  hrp_pkg::octet_t     octet,
	output logic                span_valid,
	input  wire                 span_stall,
	output hrp_pkg::span_word_t span
);
	import hrp_pkg::*;

	logic        valid_s1;
	octet_t      word_s1;
	logic        room;
	logic        fire;
	res_bundle_t results;

	assign fire = valid_s1 && room;
	assign octet_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (octet_valid && !octet_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (octet_valid && !octet_stall) begin
			word_s1 <= octet;
		end
	end

	hrp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.word_s1 (word_s1),
		.results (results)
	);

	hrp_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (results),
		.room       (room),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span       (span)
	);

`ifndef NO_ASSERTIONS
	// stall only ever comes from a held byte waiting on the queue
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		octet_stall |-> valid_s1 && !room)
		else $error("stall without a held byte");
`endif
endmodule
`default_nettype wire

[rtl/hrp_parser.sv]
// request line and header state machine, one byte per cycle while the result queue has room
`timescale 1ns / 1ps
`default_nettype none
module hrp_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 fire,
	input  hrp_pkg::octet_t     word_s1,
	output hrp_pkg::res_bundle_t results
);
	import hrp_pkg::*;

	localparam logic [3:0] PH_LINE_START = 4'd0;
	localparam logic [3:0] PH_METHOD     = 4'd1;
	localparam logic [3:0] PH_URL        = 4'd2;
	localparam logic [3:0] PH_PROTOCOL   = 4'd3;
	localparam logic [3:0] PH_SPACE_END  = 4'd4;
	localparam logic [3:0] PH_CR_END     = 4'd5;
	localparam logic [3:0] PH_HEAD_START = 4'd6;
	localparam logic [3:0] PH_KEY        = 4'd7;
	localparam logic [3:0] PH_SP_BEFORE  = 4'd8;
	localparam logic [3:0] PH_SP_AFTER   = 4'd9;
	localparam logic [3:0] PH_VALUE      = 4'd10;
	localparam logic [3:0] PH_CR         = 4'd11;
	localparam logic [3:0] PH_CRLF       = 4'd12;
	localparam logic [3:0] PH_CRLFCR     = 4'd13;

	localparam logic [3:0] EV_NONE       = 4'd0;
	localparam logic [3:0] EV_METHOD     = 4'd0;
	localparam logic [3:0] EV_URL        = 4'd1;
	localparam logic [3:0] EV_PROTOCOL   = 4'd2;
	localparam logic [3:0] EV_LINE       = 4'd3;
	localparam logic [3:0] EV_KEY        = 4'd4;
	localparam logic [3:0] EV_VALUE      = 4'd5;
	localparam logic [3:0] EV_HEAD_END   = 4'd6;
	localparam logic [3:0] EV_ERR_METHOD = 4'd7;
	localparam logic [3:0] EV_ERR_LINE   = 4'd8;
	localparam logic [3:0] EV_ERR_HEAD   = 4'd9;
	localparam logic [3:0] EV_TOO_LONG   = 4'd10;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5a;
	localparam logic [7:0] CH_US    = 8'h5f;

	function automatic span_word_t mk(input logic [3:0] ev, input logic [SPAN_W-1:0] s,
		input logic [SPAN_W-1:0] e);
		span_word_t w;
		w.event_res   = ev;
		w.span_start  = s;
		w.span_end    = e;
		w.last_of_run = 1'b0;
		return w;
	endfunction

	function automatic logic method_char(input logic [7:0] c);
		return (c inside {[CH_A:CH_Z]}) || (c == CH_US);
	endfunction

	logic [3:0]        phase_q, phase_d, phase_e;
	logic              lock_q, lock_d, lock_e;
	logic [OFS_W-1:0]  ofs_q, ofs_d, ofs_e;
	logic [SPAN_W-1:0] method_begin_q, method_stop_q, url_stop_q, protocol_stop_q;
	logic [SPAN_W-1:0] key_begin_q, key_stop_q, value_begin_q, value_stop_q;
	logic [SPAN_W-1:0] method_begin_d, method_stop_d, url_stop_d, protocol_stop_d;
	logic [SPAN_W-1:0] key_begin_d, key_stop_d, value_begin_d, value_stop_d;
	logic [SPAN_W-1:0] p;
	logic [7:0]        ch;
	logic [3:0]        err;
	logic              err_hit;
	logic [RES_CNT_W-1:0] n;
	span_word_t [MAX_RES-1:0] item;

	always_comb begin
		phase_d = phase_q;
		lock_d = lock_q;
		ofs_d = ofs_q;
		method_begin_d = method_begin_q;
		method_stop_d = method_stop_q;
		url_stop_d = url_stop_q;
		protocol_stop_d = protocol_stop_q;
		key_begin_d = key_begin_q;
		key_stop_d = key_stop_q;
		value_begin_d = value_begin_q;
		value_stop_d = value_stop_q;
		phase_e = word_s1.restart ? PH_LINE_START : phase_q;
		lock_e = word_s1.restart ? 1'b0 : lock_q;
		ofs_e = word_s1.restart ? '0 : ofs_q;
		p = SPAN_W'(ofs_e);
		ch = word_s1.data_byte;
		err = EV_NONE;
		err_hit = 1'b0;
		n = '0;
		item = '0;
		if (fire) begin
			phase_d = phase_e;
			lock_d = lock_e;
			ofs_d = ofs_e;
			if (!lock_e) begin
				if (ofs_e >= OFS_W'(MAX_REQUEST_BYTES)) begin
					lock_d = 1'b1;
					item[0] = mk(EV_TOO_LONG, '0, '0);
					n = RES_CNT_W'(1);
				end else begin
					case (phase_e)
						PH_METHOD: begin
							if (ch == CH_SPACE) begin
								method_stop_d = p;
								phase_d = PH_URL;
							end else if (!method_char(ch)) begin
								err = EV_ERR_METHOD;
								err_hit = 1'b1;
							end
						end
						PH_URL: begin
							if (ch == CH_SPACE) begin
								url_stop_d = p;
								phase_d = PH_PROTOCOL;
							end
						end
						PH_PROTOCOL: begin
							if (ch == CH_SPACE) begin
								protocol_stop_d = p;
								phase_d = PH_SPACE_END;
							end else if (ch == CH_CR) begin
								protocol_stop_d = p;
								phase_d = PH_CR_END;
							end
						end
						PH_SPACE_END: begin
							if (ch == CH_CR) begin
								phase_d = PH_CR_END;
							end else if (ch != CH_SPACE) begin
								err = EV_ERR_LINE;
								err_hit = 1'b1;
							end
						end
						PH_CR_END: begin
							if (ch == CH_LF) begin
								item[0] = mk(EV_METHOD, method_begin_q, method_stop_q);
								item[1] = mk(EV_URL, method_stop_q + 1'b1, url_stop_q);
								item[2] = mk(EV_PROTOCOL, url_stop_q + 1'b1, protocol_stop_q);
								item[3] = mk(EV_LINE, method_begin_q, p - 1'b1);
								n = RES_CNT_W'(4);
								phase_d = PH_HEAD_START;
							end else begin
								err = EV_ERR_LINE;
								err_hit = 1'b1;
							end
						end
						PH_HEAD_START: begin
							if (ch != CH_CR && ch != CH_LF) begin
								key_begin_d = p;
								phase_d = PH_KEY;
							end
						end
						PH_KEY: begin
							if (ch == CH_SPACE) begin
								key_stop_d = p;
								phase_d = PH_SP_BEFORE;
							end else if (ch == CH_COLON) begin
								key_stop_d = p;
								phase_d = PH_SP_AFTER;
							end
						end
						PH_SP_BEFORE: begin
							if (ch == CH_COLON) begin
								phase_d = PH_SP_AFTER;
							end else if (ch != CH_SPACE) begin
								err = EV_ERR_HEAD;
								err_hit = 1'b1;
							end
						end
						PH_SP_AFTER: begin
							if (ch != CH_SPACE) begin
								value_begin_d = p;
								phase_d = PH_VALUE;
							end
						end
						PH_VALUE: begin
							if (ch == CH_CR) begin
								value_stop_d = p;
								phase_d = PH_CR;
							end else if (ch == CH_LF) begin
								value_stop_d = p;
								phase_d = PH_CRLF;
							end
						end
						PH_CR: begin
							if (ch == CH_LF) begin
								item[0] = mk(EV_KEY, key_begin_q, key_stop_q);
								item[1] = mk(EV_VALUE, value_begin_q, value_stop_q);
								n = RES_CNT_W'(2);
								phase_d = PH_CRLF;
							end else begin
								err = EV_ERR_HEAD;
								err_hit = 1'b1;
							end
						end
						PH_CRLF: begin
							if (ch == CH_CR) begin
								phase_d = PH_CRLFCR;
							end else begin
								key_begin_d = p;
								phase_d = PH_KEY;
							end
						end
						PH_CRLFCR: begin
							if (ch == CH_LF) begin
								item[0] = mk(EV_HEAD_END, '0, '0);
								n = RES_CNT_W'(1);
								phase_d = PH_HEAD_START;
							end else begin
								err = EV_ERR_HEAD;
								err_hit = 1'b1;
							end
						end
						default: begin
							if (ch != CH_CR && ch != CH_LF) begin
								if (!method_char(ch)) begin
									err = EV_ERR_METHOD;
									err_hit = 1'b1;
								end else begin
									method_begin_d = p;
									phase_d = PH_METHOD;
								end
							end
						end
					endcase
					if (err_hit) begin
						lock_d = 1'b1;
						item = '0;
						item[0] = mk(err, '0, '0);
						n = RES_CNT_W'(1);
					end
					ofs_d = ofs_e + 1'b1;
				end
			end
		end
		for (int i = 0; i < MAX_RES; i++) begin
			if (n == RES_CNT_W'(i + 1)) begin
				item[i].last_of_run = 1'b1;
			end
		end
		results.cnt = n;
		results.item = item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_START;
			lock_q <= 1'b0;
			ofs_q <= '0;
		end else begin
			phase_q <= phase_d;
			lock_q <= lock_d;
			ofs_q <= ofs_d;
		end
	end

	always_ff @(posedge clk) begin
		method_begin_q <= method_begin_d;
		method_stop_q <= method_stop_d;
		url_stop_q <= url_stop_d;
		protocol_stop_q <= protocol_stop_d;
		key_begin_q <= key_begin_d;
		key_stop_q <= key_stop_d;
		value_begin_q <= value_begin_d;
		value_stop_q <= value_stop_d;
	end

`ifndef NO_ASSERTIONS
	// a locked parser stays locked until a restart word is taken
	a_lock_holds: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q && !(fire && word_s1.restart) |=> lock_q)
		else $error("error lock dropped without restart");

	// offset never runs past capacity
	a_ofs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ofs_q <= OFS_W'(MAX_REQUEST_BYTES))
		else $error("byte offset beyond capacity");

	// a locked parser without restart emits nothing
	a_lock_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q && !word_s1.restart |-> results.cnt == '0)
		else $error("results while locked");
`endif
endmodule
`default_nettype wire

[rtl/hrp_result_fifo.sv]
// result queue, takes up to four words a cycle and hands out one while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none
module hrp_result_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  hrp_pkg::res_bundle_t push,
	output logic                 room,
	output logic                 span_valid,
	input  wire                  span_stall,
	output hrp_pkg::span_word_t  span
);
	import hrp_pkg::*;

	localparam int IDX_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	span_word_t        mem_q [FIFO_DEPTH];
	logic [IDX_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	assign span_valid = (count_q != '0);
	assign span = mem_q[head_q];
	assign pop = span_valid && !span_stall;
	assign room = (count_q <= CNT_W'(FIFO_DEPTH - MAX_RES));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (RES_CNT_W'(i) < push.cnt) begin
				mem_q[tail_q + IDX_W'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_q + IDX_W'(pop);
			tail_q <= tail_q + IDX_W'(push.cnt);
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	// words are only pushed while four slots are free
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != '0 |-> room)
		else $error("push without room");

	// fill level stays within depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("queue overfilled");
`endif
endmodule
`default_nettype wire
